FILE: sv/crtb_pkg.sv
// ----------------------------------------------------------------------------
// crtb_pkg
// shared constants, register indexes and structs of the clipped text block
// renderer
// ----------------------------------------------------------------------------
`default_nettype none

package crtb_pkg;

   // width of the saturating character counter
   localparam int COUNT_BITS = 16;
   // width at which the counter is compared with the limit
   localparam int CMP_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_TEXT_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TEXT_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIGIN_ROW  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIGIN_COL  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_MODE = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_ROWS = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_COLS = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHAR_LIMIT  = 3'd7;

   // register reset values
   localparam logic [7:0]         RST_TEXT_WIDTH  = 8'd80;
   localparam logic [7:0]         RST_TEXT_HEIGHT = 8'd25;
   localparam logic signed [11:0] RST_ORIGIN_ROW  = 12'sd0;
   localparam logic signed [11:0] RST_ORIGIN_COL  = 12'sd0;
   localparam logic               RST_CENTER_MODE = 1'b0;
   localparam logic [10:0]        RST_SCREEN_ROWS = 11'd25;
   localparam logic [10:0]        RST_SCREEN_COLS = 11'd80;
   localparam logic signed [16:0] RST_CHAR_LIMIT  = -17'sd1;

   // character codes
   localparam logic [7:0] NEWLINE_CODE  = 8'd10;
   localparam logic [7:0] TEXT_END_CODE = 8'd0;

   // largest usable screen dimension
   localparam logic [10:0] SCREEN_MAX = 11'd1024;

   typedef struct packed {
      logic [7:0]         text_width;
      logic [7:0]         text_height;
      logic signed [11:0] origin_row;
      logic signed [11:0] origin_col;
      logic               center_mode;
      logic [10:0]        screen_rows;
      logic [10:0]        screen_cols;
      logic signed [16:0] char_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0]            row_index;
      logic [7:0]            col_index;
      logic [COUNT_BITS-1:0] chars_counted;
      logic                  stopped;
   } state_type;

   typedef struct packed {
      logic       write_valid;
      logic [9:0] screen_y;
      logic [9:0] screen_x;
      logic [7:0] glyph;
      logic       finished;
   } result_type;

endpackage

`default_nettype wire

FILE: sv/crtb_csr.sv
// ----------------------------------------------------------------------------
// crtb_csr
// configuration registers, written through a plain index/data write port
// ----------------------------------------------------------------------------
`default_nettype none

module crtb_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [crtb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [crtb_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output crtb_pkg::cfg_type                         cfg
);

   crtb_pkg::cfg_type cfg_ff;
   crtb_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            crtb_pkg::REG_TEXT_WIDTH:  cfg_in.text_width  = csr_wdata[7:0];
            crtb_pkg::REG_TEXT_HEIGHT: cfg_in.text_height = csr_wdata[7:0];
            crtb_pkg::REG_ORIGIN_ROW:  cfg_in.origin_row  = $signed(csr_wdata[11:0]);
            crtb_pkg::REG_ORIGIN_COL:  cfg_in.origin_col  = $signed(csr_wdata[11:0]);
            crtb_pkg::REG_CENTER_MODE: cfg_in.center_mode = csr_wdata[0];
            crtb_pkg::REG_SCREEN_ROWS: cfg_in.screen_rows = csr_wdata[10:0];
            crtb_pkg::REG_SCREEN_COLS: cfg_in.screen_cols = csr_wdata[10:0];
            crtb_pkg::REG_CHAR_LIMIT:  cfg_in.char_limit  = $signed(csr_wdata[16:0]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_width  <= crtb_pkg::RST_TEXT_WIDTH;
         cfg_ff.text_height <= crtb_pkg::RST_TEXT_HEIGHT;
         cfg_ff.origin_row  <= crtb_pkg::RST_ORIGIN_ROW;
         cfg_ff.origin_col  <= crtb_pkg::RST_ORIGIN_COL;
         cfg_ff.center_mode <= crtb_pkg::RST_CENTER_MODE;
         cfg_ff.screen_rows <= crtb_pkg::RST_SCREEN_ROWS;
         cfg_ff.screen_cols <= crtb_pkg::RST_SCREEN_COLS;
         cfg_ff.char_limit  <= crtb_pkg::RST_CHAR_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: sv/crtb_step.sv
// ----------------------------------------------------------------------------
// crtb_step
// per-character placement: clipping, row/column stepping, count and stop
// ----------------------------------------------------------------------------
`default_nettype none

module crtb_step (
   input  wire crtb_pkg::cfg_type   cfg,
   input  wire crtb_pkg::state_type state,
   input  wire logic                first_char,
   input  wire logic [7:0]          ch,
   output crtb_pkg::state_type      state_next,
   output crtb_pkg::result_type     result
);

   localparam int CB = crtb_pkg::COUNT_BITS;
   localparam int CW = crtb_pkg::CMP_BITS;

   crtb_pkg::state_type st;

   logic [10:0]        eff_rows;
   logic [10:0]        eff_cols;
   logic signed [12:0] top_row;
   logic signed [12:0] left_col;
   logic [7:0]         row_inc;
   logic signed [13:0] cur_y;
   logic signed [13:0] next_y;
   logic signed [13:0] cur_x;
   logic               cur_end;
   logic               next_end;
   logic               limit_hit;
   logic [CB-1:0]      count_inc;
   logic               is_newline;

   // a new block starts from cleared state
   assign st = first_char ? '0 : state;

   assign eff_rows = (cfg.screen_rows > crtb_pkg::SCREEN_MAX) ? crtb_pkg::SCREEN_MAX
                                                               : cfg.screen_rows;
   assign eff_cols = (cfg.screen_cols > crtb_pkg::SCREEN_MAX) ? crtb_pkg::SCREEN_MAX
                                                               : cfg.screen_cols;

   assign top_row  = cfg.center_mode
                     ? ($signed({cfg.origin_row[11], cfg.origin_row})
                        - $signed({6'b0, cfg.text_height[7:1]}))
                     : $signed({cfg.origin_row[11], cfg.origin_row});
   assign left_col = cfg.center_mode
                     ? ($signed({cfg.origin_col[11], cfg.origin_col})
                        - $signed({6'b0, cfg.text_width[7:1]}))
                     : $signed({cfg.origin_col[11], cfg.origin_col});

   assign row_inc = st.row_index + 8'd1;
   assign cur_y   = $signed({top_row[12], top_row}) + $signed({6'b0, st.row_index});
   assign next_y  = $signed({top_row[12], top_row}) + $signed({6'b0, row_inc});
   assign cur_x   = $signed({left_col[12], left_col}) + $signed({6'b0, st.col_index});

   assign cur_end  = (st.row_index >= cfg.text_height)
                     || (cur_y >= $signed({3'b0, eff_rows}));
   assign next_end = (row_inc >= cfg.text_height)
                     || (next_y >= $signed({3'b0, eff_rows}));

   assign limit_hit = !cfg.char_limit[16]
                      && ({{(CW-CB){1'b0}}, st.chars_counted}
                          >= {{(CW-16){1'b0}}, cfg.char_limit[15:0]});

   // saturating count
   assign count_inc = (&st.chars_counted) ? st.chars_counted
                                          : st.chars_counted + {{(CB-1){1'b0}}, 1'b1};

   assign is_newline = (ch == crtb_pkg::NEWLINE_CODE);

   always_comb begin
      state_next = st;
      result     = '0;
      if (!st.stopped) begin
         priority if ((cfg.text_width == 8'd0) || (cfg.text_height == 8'd0)
                      || (ch == crtb_pkg::TEXT_END_CODE) || cur_end) begin
            state_next.stopped = 1'b1;
         end else if (cur_y < 14'sd0) begin
            // row above the screen: consumed, not drawn, limit does not stop
            if (!limit_hit) begin
               state_next.chars_counted = count_inc;
            end
            if (is_newline) begin
               state_next.row_index = row_inc;
               state_next.col_index = 8'd0;
               if (next_end) begin
                  state_next.stopped = 1'b1;
               end
            end
         end else if (limit_hit) begin
            state_next.stopped = 1'b1;
         end else if (is_newline) begin
            state_next.chars_counted = count_inc;
            state_next.row_index     = row_inc;
            state_next.col_index     = 8'd0;
            if (next_end) begin
               state_next.stopped = 1'b1;
            end
         end else begin
            if (st.col_index < cfg.text_width) begin
               if ((cur_x >= 14'sd0) && (cur_x < $signed({3'b0, eff_cols}))) begin
                  result.write_valid = 1'b1;
                  result.screen_y    = cur_y[9:0];
                  result.screen_x    = cur_x[9:0];
                  result.glyph       = ch;
               end
               state_next.col_index = st.col_index + 8'd1;
            end
            state_next.chars_counted = count_inc;
         end
      end
      result.finished = state_next.stopped;
   end

endmodule

`default_nettype wire

FILE: sv/clipped_text_block_renderer.sv
// ----------------------------------------------------------------------------
// clipped_text_block_renderer
// turns a streamed text block into clipped character-cell writes
// ----------------------------------------------------------------------------
// Each request carries one text byte (and a first_char flag that starts a new
// block) and produces exactly one response: a cell write (row, column, glyph)
// when the byte lands on screen, or an empty write, plus the finished flag.
// The block takes one request per clock and keeps that rate as long as
// responses are taken every cycle; a request passes through the input
// register and then the response register, and its response is presented
// once the request has moved into the response register. Between those
// registers sits the single placement step, which reads and updates the
// row, column, count and stop state in the same cycle.
// Configuration registers are to be written through the csr port only
// while no request is in flight, which the block itself does not enforce;
// they take effect for the next request.
`default_nettype none

module clipped_text_block_renderer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic                                req_first_char,
   input  wire logic [7:0]                          req_ch,
   // response channel
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_write_valid,
   output      logic [9:0]                          rsp_screen_y,
   output      logic [9:0]                          rsp_screen_x,
   output      logic [7:0]                          rsp_glyph,
   output      logic                                rsp_finished,
   // configuration write port
   input  wire logic                                csr_wr_en,
   input  wire logic [crtb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [crtb_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   crtb_pkg::cfg_type    cfg;
   crtb_pkg::state_type  state_ff;
   crtb_pkg::state_type  state_in;
   crtb_pkg::result_type step_result;
   crtb_pkg::result_type rsp_ff;

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic       in_first_ff;
   logic [7:0] in_ch_ff;

   // response register valid
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   logic       req_take;
   logic       advance;

   crtb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   crtb_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .first_char (in_first_ff),
      .ch         (in_ch_ff),
      .state_next (state_in),
      .result     (step_result)
   );

   // the held request moves on when the response slot is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_first_ff <= req_first_char;
         in_ch_ff    <= req_ch;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_valid = rsp_ff.write_valid;
   assign rsp_screen_y    = rsp_ff.screen_y;
   assign rsp_screen_x    = rsp_ff.screen_x;
   assign rsp_glyph       = rsp_ff.glyph;
   assign rsp_finished    = rsp_ff.finished;

endmodule

`default_nettype wire

FILE: sv/crtb_checker.sv
// ----------------------------------------------------------------------------
// crtb_checker
// port-level checks of the clipped text block renderer, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

module crtb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_write_valid,
   input wire logic [9:0] rsp_screen_y,
   input wire logic [9:0] rsp_screen_x,
   input wire logic [7:0] rsp_glyph,
   input wire logic       rsp_finished
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a placed glyph never comes with a stopped block
   a_write_not_finished: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_valid) |-> !rsp_finished)
      else $error("glyph written while finished");

   // an empty write carries zero coordinates and glyph
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_valid)
      |-> (rsp_screen_y == 10'd0 && rsp_screen_x == 10'd0 && rsp_glyph == 8'd0))
      else $error("empty write with nonzero payload");

   // newline and text end are never drawn
   a_glyph_printable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_valid) |-> (rsp_glyph != 8'd0 && rsp_glyph != 8'd10))
      else $error("control byte drawn");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_glyph)
                                    && $stable(rsp_finished)))
      else $error("stalled response changed");

endmodule

bind clipped_text_block_renderer crtb_checker u_crtb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_write_valid (rsp_write_valid),
   .rsp_screen_y    (rsp_screen_y),
   .rsp_screen_x    (rsp_screen_x),
   .rsp_glyph       (rsp_glyph),
   .rsp_finished    (rsp_finished)
);

`default_nettype wire

FILE: test/tb_clipped_text_block_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clipped_text_block_renderer
// self-checking bench for the clipped text block renderer
// ----------------------------------------------------------------------------
// Streams text bytes into the renderer, predicts each cell write with an
// in-bench placement model and compares every response field by field.
// Runs hand-picked edge cases and randomized text blocks under many register
// settings, with random gaps on both channels and one long response hold-off.
// ----------------------------------------------------------------------------

module tb_clipped_text_block_renderer;

   localparam int RANDOM_ITEMS = 500;   // rough size of the random part
   localparam int LONG_HOLD    = 120;   // cycles of the long response hold
   localparam int DRAIN_CYCLES = 6;     // settle time after the last response

   typedef struct packed {
      logic       first;
      logic [7:0] code;
   } text_byte_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // dut ports; the inputs are known from time zero
   logic                                req_valid      = 1'b0;
   logic                                req_stall;
   logic                                req_first_char = 1'b0;
   logic [7:0]                          req_ch         = '0;
   logic                                rsp_valid;
   logic                                rsp_stall      = 1'b0;
   logic                                rsp_write_valid;
   logic [9:0]                          rsp_screen_y;
   logic [9:0]                          rsp_screen_x;
   logic [7:0]                          rsp_glyph;
   logic                                rsp_finished;
   logic                                csr_wr_en      = 1'b0;
   logic [crtb_pkg::CSR_INDEX_BITS-1:0] csr_index      = '0;
   logic [crtb_pkg::CSR_DATA_BITS-1:0]  csr_wdata      = '0;

   clipped_text_block_renderer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_first_char  (req_first_char),
      .req_ch          (req_ch),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_write_valid (rsp_write_valid),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_glyph       (rsp_glyph),
      .rsp_finished    (rsp_finished),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // placement model: register copy plus row / column / count / stop state
   // ------------------------------------------------------------------------
   crtb_pkg::cfg_type               model_cfg;
   logic [7:0]                      blk_row;
   logic [7:0]                      blk_col;
   logic [crtb_pkg::COUNT_BITS-1:0] char_count;
   logic                            halted;

   // bytes waiting to be sent and cell writes waiting to come back
   text_byte_type        pending_bytes[$];
   crtb_pkg::result_type expected_cells[$];

   // bookkeeping
   int bytes_queued   = 0;
   int bytes_accepted = 0;
   int cells_checked  = 0;
   int cells_drawn    = 0;
   int fail_count     = 0;
   int settings_used  = 0;

   // pacing controls, written by the stimulus process
   logic idle_on    = 1'b1;
   logic hold_armed = 1'b0;

   // current row is past the block's height or past the bottom of the screen
   function automatic bit block_done(input int top, input int rows_vis);
      return (int'(blk_row) >= int'(model_cfg.text_height)) ||
             (top + int'(blk_row) >= rows_vis);
   endfunction

   // consumes one byte and returns the cell write it causes
   function automatic crtb_pkg::result_type place_char(input logic first,
                                                        input logic [7:0] code);
      crtb_pkg::result_type placed;
      int         rows_vis;
      int         cols_vis;
      int         top;
      int         left;
      int         out_y;
      int         out_x;
      int         limit;
      bit         at_limit;
      placed = '0;
      if (first) begin
         blk_row    = '0;
         blk_col    = '0;
         char_count = '0;
         halted     = 1'b0;
      end
      // screens larger than the addressable range clip at its edge
      rows_vis = (model_cfg.screen_rows > crtb_pkg::SCREEN_MAX)
                 ? int'(crtb_pkg::SCREEN_MAX) : int'(model_cfg.screen_rows);
      cols_vis = (model_cfg.screen_cols > crtb_pkg::SCREEN_MAX)
                 ? int'(crtb_pkg::SCREEN_MAX) : int'(model_cfg.screen_cols);
      top  = $signed(model_cfg.origin_row);
      left = $signed(model_cfg.origin_col);
      if (model_cfg.center_mode) begin
         top  = top - int'(model_cfg.text_height >> 1);
         left = left - int'(model_cfg.text_width >> 1);
      end
      limit    = $signed(model_cfg.char_limit);
      at_limit = (limit >= 0) && (longint'(char_count) >= longint'(limit));

      if (!halted) begin
         out_y = top + int'(blk_row);
         if (model_cfg.text_width == 0 || model_cfg.text_height == 0 ||
             code == crtb_pkg::TEXT_END_CODE || block_done(top, rows_vis)) begin
            halted = 1'b1;
         end else if (out_y < 0) begin
            // row above the screen: consumed, counted up to the limit only
            if (!at_limit && char_count != {crtb_pkg::COUNT_BITS{1'b1}})
               char_count = char_count + 1'b1;
            if (code == crtb_pkg::NEWLINE_CODE) begin
               blk_row = blk_row + 1'b1;
               blk_col = '0;
               if (block_done(top, rows_vis))
                  halted = 1'b1;
            end
         end else if (at_limit) begin
            halted = 1'b1;
         end else if (code == crtb_pkg::NEWLINE_CODE) begin
            if (char_count != {crtb_pkg::COUNT_BITS{1'b1}})
               char_count = char_count + 1'b1;
            blk_row = blk_row + 1'b1;
            blk_col = '0;
            if (block_done(top, rows_vis))
               halted = 1'b1;
         end else begin
            // column holds at the width once a line is cut
            if (blk_col < model_cfg.text_width) begin
               out_x = left + int'(blk_col);
               if (out_x >= 0 && out_x < cols_vis) begin
                  placed.write_valid = 1'b1;
                  placed.screen_y    = out_y[9:0];
                  placed.screen_x    = out_x[9:0];
                  placed.glyph       = code;
               end
               blk_col = blk_col + 1'b1;
            end
            if (char_count != {crtb_pkg::COUNT_BITS{1'b1}})
               char_count = char_count + 1'b1;
         end
      end
      placed.finished = halted;
      return placed;
   endfunction

   // ------------------------------------------------------------------------
   // request driver: one byte at a time from the pending queue, with a random
   // gap after each accepted request
   // ------------------------------------------------------------------------
   int            send_wait = 0;
   text_byte_type next_byte;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         // prediction happens at the accepting edge, so expectations stay in order
         if (req_valid && !req_stall) begin
            expected_cells.push_back(place_char(req_first_char, req_ch));
            bytes_accepted++;
         end
         // a held request keeps its payload until it is taken
         if (!req_valid || !req_stall) begin
            if (send_wait != 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               next_byte = pending_bytes.pop_front();
               req_valid      <= 1'b1;
               req_first_char <= next_byte.first;
               req_ch         <= next_byte.code;
               send_wait = idle_on ? $urandom_range(0, 7) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // response monitor: checks every accepted response, stalls at random and
   // once for a long stretch so the block backs up into its request side
   // ------------------------------------------------------------------------
   int                   rsp_wait   = 0;
   bit                   hold_taken = 1'b0;
   crtb_pkg::result_type want_cell;

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want_cell = expected_cells.pop_front();
               check_field("write_valid", want_cell.write_valid, rsp_write_valid);
               check_field("screen_y", want_cell.screen_y, rsp_screen_y);
               check_field("screen_x", want_cell.screen_x, rsp_screen_x);
               check_field("glyph", want_cell.glyph, rsp_glyph);
               check_field("finished", want_cell.finished, rsp_finished);
               cells_checked++;
               if (rsp_write_valid)
                  cells_drawn++;
            end
            rsp_wait = idle_on ? $urandom_range(0, 7) : 0;
         end
         // long hold-off, counted here, while the sender keeps offering
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_wait   = LONG_HOLD;
         end
         if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic first, input logic [7:0] code);
      text_byte_type item;
      item.first = first;
      item.code  = code;
      pending_bytes.push_back(item);
      bytes_queued++;
   endtask

   // wait until every queued request has come back, then let the block settle
   task automatic drain();
      while (bytes_accepted != bytes_queued || expected_cells.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [crtb_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [crtb_pkg::CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         crtb_pkg::REG_TEXT_WIDTH:  model_cfg.text_width  = val[7:0];
         crtb_pkg::REG_TEXT_HEIGHT: model_cfg.text_height = val[7:0];
         crtb_pkg::REG_ORIGIN_ROW:  model_cfg.origin_row  = val[11:0];
         crtb_pkg::REG_ORIGIN_COL:  model_cfg.origin_col  = val[11:0];
         crtb_pkg::REG_CENTER_MODE: model_cfg.center_mode = val[0];
         crtb_pkg::REG_SCREEN_ROWS: model_cfg.screen_rows = val[10:0];
         crtb_pkg::REG_SCREEN_COLS: model_cfg.screen_cols = val[10:0];
         crtb_pkg::REG_CHAR_LIMIT:  model_cfg.char_limit  = val[16:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // only touches registers once the block has gone idle
   task automatic reconfigure(input crtb_pkg::cfg_type c);
      drain();
      write_reg(crtb_pkg::REG_TEXT_WIDTH,  {9'd0, c.text_width});
      write_reg(crtb_pkg::REG_TEXT_HEIGHT, {9'd0, c.text_height});
      write_reg(crtb_pkg::REG_ORIGIN_ROW,  {{5{c.origin_row[11]}}, c.origin_row});
      write_reg(crtb_pkg::REG_ORIGIN_COL,  {{5{c.origin_col[11]}}, c.origin_col});
      write_reg(crtb_pkg::REG_CENTER_MODE, {16'd0, c.center_mode});
      write_reg(crtb_pkg::REG_SCREEN_ROWS, {6'd0, c.screen_rows});
      write_reg(crtb_pkg::REG_SCREEN_COLS, {6'd0, c.screen_cols});
      write_reg(crtb_pkg::REG_CHAR_LIMIT,  c.char_limit);
      settings_used++;
   endtask

   function automatic crtb_pkg::cfg_type reset_cfg();
      crtb_pkg::cfg_type c;
      c.text_width  = crtb_pkg::RST_TEXT_WIDTH;
      c.text_height = crtb_pkg::RST_TEXT_HEIGHT;
      c.origin_row  = crtb_pkg::RST_ORIGIN_ROW;
      c.origin_col  = crtb_pkg::RST_ORIGIN_COL;
      c.center_mode = crtb_pkg::RST_CENTER_MODE;
      c.screen_rows = crtb_pkg::RST_SCREEN_ROWS;
      c.screen_cols = crtb_pkg::RST_SCREEN_COLS;
      c.char_limit  = crtb_pkg::RST_CHAR_LIMIT;
      return c;
   endfunction

   // mostly small blocks near a small screen so text lands on it, with the
   // odd full-range value for every register
   function automatic crtb_pkg::cfg_type random_cfg();
      crtb_pkg::cfg_type c;
      int      pick;
      c.text_width  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(1, 16));
      c.text_height = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(1, 8));
      c.screen_rows = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                                  : 11'($urandom_range(1, 12));
      c.screen_cols = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                                  : 11'($urandom_range(1, 20));
      c.origin_row  = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                                  : 12'(int'($urandom_range(0, 14)) - 4);
      c.origin_col  = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                                  : 12'(int'($urandom_range(0, 22)) - 4);
      c.center_mode = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1:    c.char_limit = 17'($urandom_range(0, 40));
         2:       c.char_limit = 17'd65535;
         3:       c.char_limit = 17'($urandom_range(65536, 131071));  // negative
         4:       c.char_limit = 17'($urandom_range(0, 65535));
         default: c.char_limit = '1;
      endcase
      return c;
   endfunction

   // one text block: rows of random bytes ended by newlines and sometimes a
   // text end; now and then plain noise or a block without its start flag
   task automatic queue_random_block();
      int rows;
      int len;
      bit lead;
      rows = $urandom_range(1, 7);
      lead = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 6))
            push_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
         for (int r = 0; r < rows; r++) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40)
                                              : $urandom_range(0, 10);
            repeat (len) begin
               push_byte(lead, 8'($urandom_range(1, 255)));
               lead = 1'b0;
            end
            if (r == rows - 1 && $urandom_range(0, 1) == 1)
               push_byte(lead, crtb_pkg::TEXT_END_CODE);
            else
               push_byte(lead, crtb_pkg::NEWLINE_CODE);
            lead = 1'b0;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      crtb_pkg::cfg_type c;
      int      random_base;
      int      phase_end;

      model_cfg  = reset_cfg();
      blk_row    = '0;
      blk_col    = '0;
      char_count = '0;
      halted     = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: byte extremes, newline, text end, then a byte that a
      // stopped block must ignore
      push_byte(1'b1, 8'h41);
      push_byte(1'b0, 8'hFF);
      push_byte(1'b0, crtb_pkg::NEWLINE_CODE);
      push_byte(1'b0, 8'h01);
      push_byte(1'b0, crtb_pkg::TEXT_END_CODE);
      push_byte(1'b0, 8'h42);

      // bottom-right corner of a large screen, line cut and row limit
      c = reset_cfg();
      c.text_width  = 8'd2;
      c.text_height = 8'd2;
      c.origin_row  = 12'sd1022;
      c.origin_col  = 12'sd1022;
      c.screen_rows = 11'd2047;
      c.screen_cols = 11'd1025;
      reconfigure(c);
      push_byte(1'b1, 8'h61);
      push_byte(1'b0, 8'h62);
      push_byte(1'b0, 8'h63);
      push_byte(1'b0, crtb_pkg::NEWLINE_CODE);
      push_byte(1'b0, 8'h64);
      push_byte(1'b0, crtb_pkg::NEWLINE_CODE);

      // row above the screen counts only up to the limit, which then stops
      // the block on the first visible byte
      c = reset_cfg();
      c.text_width  = 8'd3;
      c.text_height = 8'd5;
      c.origin_row  = -12'sd1;
      c.origin_col  = -12'sd1;
      c.screen_rows = 11'd3;
      c.screen_cols = 11'd2;
      c.char_limit  = 17'sd3;
      reconfigure(c);
      push_byte(1'b1, 8'h61);
      push_byte(1'b0, 8'h62);
      push_byte(1'b0, 8'h63);
      push_byte(1'b0, 8'h64);
      push_byte(1'b0, crtb_pkg::NEWLINE_CODE);
      push_byte(1'b0, 8'h65);

      // centred block clipped on the right, newline runs off the bottom
      c = reset_cfg();
      c.text_width  = 8'd3;
      c.text_height = 8'd3;
      c.origin_row  = 12'sd5;
      c.origin_col  = 12'sd5;
      c.center_mode = 1'b1;
      c.screen_rows = 11'd5;
      c.screen_cols = 11'd5;
      c.char_limit  = 17'sd65535;
      reconfigure(c);
      push_byte(1'b1, 8'h61);
      push_byte(1'b0, 8'h62);
      push_byte(1'b0, 8'h63);
      push_byte(1'b0, 8'h64);
      push_byte(1'b0, crtb_pkg::NEWLINE_CODE);

      // zero width stops at once
      c = reset_cfg();
      c.text_width = 8'd0;
      reconfigure(c);
      push_byte(1'b1, 8'h71);

      // zero height stops at once
      c = reset_cfg();
      c.text_height = 8'd0;
      reconfigure(c);
      push_byte(1'b1, 8'h71);

      // block starts below the screen
      c = reset_cfg();
      c.origin_row = 12'sd2047;
      c.origin_col = -12'sd2048;
      reconfigure(c);
      push_byte(1'b1, 8'h71);

      // a limit of zero stops before the first visible byte
      c = reset_cfg();
      c.char_limit = 17'sd0;
      reconfigure(c);
      push_byte(1'b1, 8'h71);

      // most negative limit means no limit; full-size block centred far off
      c = reset_cfg();
      c.text_width  = 8'd255;
      c.text_height = 8'd255;
      c.origin_row  = -12'sd2048;
      c.center_mode = 1'b1;
      c.char_limit  = 17'h10000;
      reconfigure(c);
      push_byte(1'b1, 8'h71);

      // random text blocks under random settings
      random_base = bytes_queued;
      while (bytes_queued - random_base < RANDOM_ITEMS) begin
         reconfigure(random_cfg());
         idle_on <= ($urandom_range(0, 3) != 0);
         phase_end = bytes_queued + $urandom_range(40, 100);
         while (bytes_queued < phase_end)
            queue_random_block();
         // first random phase: hold responses back while requests pile up
         if (!hold_armed)
            hold_armed <= 1'b1;
      end

      drain();

      $display("summary: %0d requests compared field by field, %0d of them drew a cell",
               cells_checked, cells_drawn);
      $display("summary: %0d register settings, %0d random requests, one %0d-cycle response hold",
               settings_used, bytes_queued - random_base, LONG_HOLD);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog: well beyond the slowest legal run of all requests
   initial begin
      #(1_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule
